/* rtl/pattern_dither_pixel_unit_defines.svh */
// Assertion macros for the pattern dither pixel unit.
// Included by the top level; no other dependencies.
`ifndef PATTERN_DITHER_PIXEL_UNIT_DEFINES_SVH
`define PATTERN_DITHER_PIXEL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only while the block is out of reset.
`define PDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PDP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PDP_ASSERT(label, prop, msg)
`define PDP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/pdp_pkg.sv */
// Types, constants and shade tables for the pattern dither pixel unit.
// Used by every module of the block; depends on nothing.
package pdp_pkg;

  localparam int SHADE_COUNT = 11;
  localparam int LUMA_DIV    = 100;
  localparam int SUM_W       = 15;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic [3:0] shade_level;
    logic       pixel_black;
  } result_t;

  localparam logic [7:0] SHADE_PATTERN [SHADE_COUNT][8] = '{
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
    '{8'hFF, 8'hFF, 8'hFF, 8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'h7F},
    '{8'hEF, 8'hFF, 8'hFE, 8'hFF, 8'hEF, 8'hFF, 8'hFE, 8'hFF},
    '{8'h77, 8'hDD, 8'h77, 8'hDD, 8'h77, 8'hDD, 8'h77, 8'hDD},
    '{8'hEE, 8'h55, 8'hBB, 8'h55, 8'hEE, 8'h55, 8'hBB, 8'h55},
    '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55},
    '{8'hAA, 8'h55, 8'hAA, 8'h51, 8'hAA, 8'h55, 8'hAA, 8'h15},
    '{8'hAA, 8'h44, 8'hAA, 8'h11, 8'hAA, 8'h44, 8'hAA, 8'h11},
    '{8'h88, 8'h00, 8'h22, 8'h00, 8'h88, 8'h00, 8'h22, 8'h00},
    '{8'h80, 8'h00, 8'h08, 8'h00, 8'h80, 8'h00, 8'h08, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Exclusive upper luminance bound of each level below the brightest.
  localparam logic [7:0] SHADE_BOUND [SHADE_COUNT-1] = '{
    8'd12, 8'd38, 8'd64, 8'd90, 8'd116, 8'd140, 8'd166, 8'd192, 8'd218, 8'd244
  };

  localparam logic [6:0] SHADE_CHAR [SHADE_COUNT] = '{
    7'h40, 7'h23, 7'h26, 7'h24, 7'h25, 7'h5A, 7'h3F, 7'h2B, 7'h3D, 7'h2E, 7'h20
  };

  localparam logic [3:0] LEVEL_DARKEST   = 4'd0;
  localparam logic [3:0] LEVEL_BRIGHTEST = 4'(SHADE_COUNT - 1);

endpackage

/* rtl/pdp_position.sv */
// Pattern row and column counters for the pattern dither pixel unit.
// Depends on pdp_pkg.
module pdp_position (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          last_in_row,
  output pdp_pkg::pos_t pos
);

  pdp_pkg::pos_t pos_r;
  pdp_pkg::pos_t pos_nxt;

  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      if (last_in_row) begin
        pos_nxt.col = 3'd0;
        pos_nxt.row = pos_r.row + 3'd1;
      end else begin
        pos_nxt.col = pos_r.col + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

/* rtl/pdp_shade.sv */
// Luminance, shade level, dither bit and character for one pixel.
// Purely combinational; depends on pdp_pkg.
module pdp_shade (
  input  pdp_pkg::pixel_t  pixel,
  input  pdp_pkg::pos_t    pos,
  output pdp_pkg::result_t result
);

  logic [pdp_pkg::SUM_W-1:0] luma_sum;
  logic [3:0]                level;
  logic [7:0]                pattern_row;

  assign luma_sum = pdp_pkg::SUM_W'(30) * {7'd0, pixel.red}
                  + pdp_pkg::SUM_W'(59) * {7'd0, pixel.green}
                  + pdp_pkg::SUM_W'(11) * {7'd0, pixel.blue};

  // The luminance is the sum divided by 100, so the bounds are scaled instead.
  always_comb begin
    level = pdp_pkg::LEVEL_DARKEST;
    for (int i = 0; i < pdp_pkg::SHADE_COUNT - 1; i++) begin
      if (luma_sum >= pdp_pkg::SUM_W'(pdp_pkg::SHADE_BOUND[i] * pdp_pkg::LUMA_DIV)) begin
        level = 4'(i + 1);
      end
    end
  end

  // Column 0 is the most significant bit of the pattern byte.
  assign pattern_row        = pdp_pkg::SHADE_PATTERN[level][pos.row];
  assign result.pixel_black = pattern_row[~pos.col];
  assign result.shade_level = level;
  assign result.ascii_char  = pdp_pkg::SHADE_CHAR[level];

endmodule

/* rtl/pattern_dither_pixel_unit.sv */
// Channel  Dir  Ports                                Data
// in       in   in_tvalid in_tready in_tdata in_tlast RGB pixel, row end flag
// out      out  out_tvalid out_tready out_tdata        black bit, level, char
//
// One pixel is taken every cycle while the output does not stall; its result passes
// through the input register and then the result register before it is offered.
// The rate is set by the input register and the result register, with the
// shade logic between them; both stages advance whenever the next one moves.
// A stalled output holds its beat while the input register may still fill.
// Reset clears the valid flags and the pattern row and column to zero.
// Depends on pdp_pkg, pdp_position, pdp_shade and the defines header.
`include "pattern_dither_pixel_unit_defines.svh"

module pattern_dither_pixel_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // pixel_black [0], shade_level [4:1], ascii_char [11:5]
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  pdp_pkg::pixel_t  s1_pix_r;
  pdp_pkg::pos_t    s1_pos_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  pdp_pkg::result_t out_res_r;
  pdp_pkg::result_t shade_res;
  pdp_pkg::pos_t    pos;
  pdp_pkg::pixel_t  in_pix;
  logic             out_free;
  logic             in_beat;
  logic             res_in_range;
  logic             res_darkest;
  logic             res_brightest;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_beat   = in_tvalid && in_tready;

  assign in_pix.red   = in_tdata[7:0];
  assign in_pix.green = in_tdata[15:8];
  assign in_pix.blue  = in_tdata[23:16];

  pdp_position u_position (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_beat),
    .last_in_row (in_tlast),
    .pos         (pos)
  );

  pdp_shade u_shade (
    .pixel  (s1_pix_r),
    .pos    (s1_pos_r),
    .result (shade_res)
  );

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pix_r <= in_pix;
      s1_pos_r <= pos;
    end
    if (out_free && s1_valid_r) begin
      out_res_r <= shade_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.ascii_char, out_res_r.shade_level,
                       out_res_r.pixel_black};

  assign res_in_range  = out_res_r.shade_level <= pdp_pkg::LEVEL_BRIGHTEST;
  assign res_darkest   = out_res_r.shade_level == pdp_pkg::LEVEL_DARKEST;
  assign res_brightest = out_res_r.shade_level == pdp_pkg::LEVEL_BRIGHTEST;

  `PDP_ASSERT(a_level_range, out_tvalid |-> res_in_range, "shade level out of range")
  `PDP_ASSERT(a_darkest_black, (out_tvalid && res_darkest) |-> out_res_r.pixel_black, "dark white")
  `PDP_ASSERT(a_brightest_white, (out_tvalid && res_brightest) |-> !out_res_r.pixel_black, "bright black")
  `PDP_ASSERT(a_row_end_col, (in_beat && in_tlast) |=> (pos.col == 3'd0), "column not cleared")
  `PDP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_tvalid && !s1_valid_r), "pipe not empty")

endmodule
